[rtl/asn1tp_pkg.sv]
// Shared types, constants and helper functions of the ASN.1 time parser.
package asn1tp_pkg;

   localparam int POSITION_LIMIT_DEF = 32;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic KIND_UTC = 1'b0;
   localparam logic KIND_GEN = 1'b1;

   localparam logic [4:0] OFFSET_RESET = 5'd8;
   localparam logic [4:0] OFFSET_MAX   = 5'd23;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   localparam logic [7:0] REQ_LEN_UTC  = 8'd10;
   localparam logic [7:0] REQ_LEN_GEN  = 8'd12;
   localparam logic [7:0] YEAR_LEN_UTC = 8'd2;
   localparam logic [7:0] YEAR_LEN_GEN = 8'd4;

   localparam logic [7:0] FIELD_MONTH = 8'd0;
   localparam logic [7:0] FIELD_DAY   = 8'd1;
   localparam logic [7:0] FIELD_HOUR  = 8'd2;

   // Accumulators of the string being parsed.
   typedef struct packed {
      logic        kind;
      logic [13:0] year;
      logic [6:0]  year_hi;
      logic [6:0]  year_lo;
      logic [6:0]  month;
      logic [6:0]  day;
      logic [6:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic        seconds_ok;
      logic        format_error;
   } parse_type;

   // Snapshot of a finished string, handed to the date stage.
   typedef struct packed {
      parse_type p;
      logic      too_short;
      logic      sec_full;
   } finish_type;

   typedef struct packed {
      logic        status;
      logic [6:0]  second;
      logic [6:0]  minute;
      logic [4:0]  hour;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } result_type;

   function automatic logic [4:0] month_days(input logic [3:0] mo);
      logic [4:0] d;
      case (mo)
         4'd2:                       d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:         d = 5'd31;
         default:                    d = 5'd0;
      endcase
      return d;
   endfunction

   // acc * 10 + dv, truncated to 14 bits
   function automatic logic [13:0] push_digit(input logic [13:0] acc, input logic [3:0] dv);
      return (acc << 3) + (acc << 1) + {10'd0, dv};
   endfunction

endpackage

[rtl/asn1tp_step.sv]
// Per-character update of the parse accumulators and the length flags.
module asn1tp_step
   import asn1tp_pkg::*;
#(
   parameter int PosWidth = 6,
   parameter int PosCap   = 32
) (
   input  parse_type             cur,
   input  logic [PosWidth-1:0]   pos,
   input  logic [7:0]            char_code,
   input  logic                  kind_in,
   output parse_type             nxt,
   output logic [PosWidth-1:0]   pos_next,
   output logic                  too_short,
   output logic                  sec_full
);

   localparam logic [7:0] CapCode = 8'(PosCap);

   logic       is_digit;
   logic [3:0] dv;
   logic [7:0] pos8;
   logic [7:0] req;
   logic [7:0] ylen;
   logic [7:0] field;
   logic [7:0] len8;

   always_comb begin
      nxt      = cur;
      pos_next = pos;
      is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      dv       = is_digit ? 4'(char_code - CHAR_ZERO) : 4'd0;
      pos8     = 8'(pos);
      if (pos8 == 8'd0) begin
         nxt.kind = kind_in;
      end
      req   = (nxt.kind == KIND_GEN) ? REQ_LEN_GEN : REQ_LEN_UTC;
      ylen  = (nxt.kind == KIND_GEN) ? YEAR_LEN_GEN : YEAR_LEN_UTC;
      field = (pos8 - ylen) >> 1;

      if (pos8 < CapCode) begin
         if (pos8 < req) begin
            if (!is_digit) begin
               nxt.format_error = 1'b1;
            end else if (pos8 < ylen) begin
               nxt.year = push_digit(cur.year, dv);
               // century digits kept apart for the leap-year test
               if ((nxt.kind == KIND_GEN) && (pos8 < 8'd2)) begin
                  nxt.year_hi = 7'(push_digit({7'd0, cur.year_hi}, dv));
               end else begin
                  nxt.year_lo = 7'(push_digit({7'd0, cur.year_lo}, dv));
               end
            end else begin
               case (field)
                  FIELD_MONTH: nxt.month  = 7'(push_digit({7'd0, cur.month}, dv));
                  FIELD_DAY:   nxt.day    = 7'(push_digit({7'd0, cur.day}, dv));
                  FIELD_HOUR:  nxt.hour   = 7'(push_digit({7'd0, cur.hour}, dv));
                  default:     nxt.minute = 7'(push_digit({7'd0, cur.minute}, dv));
               endcase
            end
         end else if (pos8 == req) begin
            nxt.seconds_ok = is_digit;
            nxt.second     = {3'd0, dv};
         end else if (pos8 == req + 8'd1) begin
            nxt.seconds_ok = cur.seconds_ok && is_digit;
            nxt.second     = 7'(push_digit({7'd0, cur.second}, dv));
         end
         pos_next = pos + 1'b1;
      end

      len8      = 8'(pos_next);
      too_short = len8 < req;
      sec_full  = len8 >= (req + 8'd2);
   end

endmodule

[rtl/asn1tp_finish.sv]
// Range checks, local-time offset and day/month/year rollover of a finished string.
module asn1tp_finish
   import asn1tp_pkg::*;
(
   input  finish_type  fin,
   input  logic [4:0]  hour_offset,
   output result_type  res
);

   logic        bad;
   logic        leap;
   logic [13:0] y;
   logic [3:0]  mo;
   logic [5:0]  d;
   logic [5:0]  hs;
   logic [4:0]  dim;

   always_comb begin
      if (fin.p.kind == KIND_UTC) begin
         y = (fin.p.year < 14'd50) ? fin.p.year + 14'd2000 : fin.p.year + 14'd1900;
      end else begin
         y = fin.p.year;
      end

      bad = fin.p.format_error || fin.too_short
         || ((fin.p.kind == KIND_GEN) && (fin.p.year == 14'd0))
         || (fin.p.month == 7'd0) || (fin.p.month > 7'd12)
         || (fin.p.day == 7'd0) || (fin.p.day > 7'd31)
         || (fin.p.hour > 7'd24);

      // a two-digit year of 00 is 2000, a leap century
      if (fin.p.year_lo == 7'd0) begin
         leap = (fin.p.kind == KIND_UTC) || (fin.p.year_hi[1:0] == 2'd0);
      end else begin
         leap = fin.p.year_lo[1:0] == 2'd0;
      end

      mo  = fin.p.month[3:0];
      d   = {1'b0, fin.p.day[4:0]};
      dim = ((mo == 4'd2) && leap) ? 5'd29 : month_days(mo);
      hs  = {1'b0, fin.p.hour[4:0]} + {1'b0, hour_offset};

      if (hs >= 6'd24) begin
         hs = hs - 6'd24;
         d  = d + 6'd1;
         if (d > {1'b0, dim}) begin
            d  = 6'd1;
            mo = mo + 4'd1;
         end
         if (mo > 4'd12) begin
            y  = y + 14'd1;
            mo = 4'd1;
         end
      end

      if (bad) begin
         res = '0;
         res.status = STATUS_BAD;
      end else begin
         res.status = STATUS_OK;
         res.year   = y;
         res.month  = mo;
         res.day    = d[4:0];
         res.hour   = hs[4:0];
         res.minute = fin.p.minute;
         res.second = (fin.p.seconds_ok && fin.sec_full) ? fin.p.second : 7'd0;
      end
   end

endmodule

[rtl/asn1_time_parse_to_local_top.sv]
// Top level of the ASN.1 time string parser with local-time offset.
//
// Takes one character of a UTCTime or GeneralizedTime string per cycle and, on the character
// marked tlast, returns the local date and time (hour offset from csr_wr_data applied, rolling
// over day, month and year) or an error status. A new character is accepted every cycle while
// the result side keeps up; a finished string is held in the finish register between the
// character update and the date rollover logic, then in the output register. A result
// waiting in the output register does not stop characters of the next string, but once a
// second finished string is held in the finish register behind it, req_tready drops until
// the output moves. Characters beyond POSITION_LIMIT (at most 63) are counted no further
// and ignored.
module asn1_time_parse_to_local_top
   import asn1tp_pkg::*;
#(
   parameter int POSITION_LIMIT = POSITION_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] string_kind
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // year[13:0] month[17:14] day[22:18] hour[27:23]
                                    // minute[34:28] second[41:35], zero above
   output logic        rsp_tuser,   // [0] status
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   localparam int PosCap   = (POSITION_LIMIT > 63) ? 63 : POSITION_LIMIT;
   localparam int PosWidth = $clog2(PosCap + 1);

   logic [4:0]          offset_ff, offset_in;
   logic [PosWidth-1:0] pos_ff, pos_in, pos_next;
   parse_type           parse_ff, parse_in, parse_next;
   logic                fin_valid_ff, fin_valid_in;
   finish_type          fin_ff, fin_in;
   logic                out_valid_ff, out_valid_in;
   result_type          out_ff, out_in, res;
   logic                too_short, sec_full;
   logic                out_free, fin_move, accept;

   asn1tp_step #(
      .PosWidth (PosWidth),
      .PosCap   (PosCap)
   ) u_step (
      .cur       (parse_ff),
      .pos       (pos_ff),
      .char_code (req_tdata),
      .kind_in   (req_tuser),
      .nxt       (parse_next),
      .pos_next  (pos_next),
      .too_short (too_short),
      .sec_full  (sec_full)
   );

   asn1tp_finish u_finish (
      .fin         (fin_ff),
      .hour_offset (offset_ff),
      .res         (res)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fin_move   = fin_valid_ff && out_free;
   assign req_tready = !fin_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      offset_in    = offset_ff;
      pos_in       = pos_ff;
      parse_in     = parse_ff;
      fin_valid_in = fin_valid_ff;
      fin_in       = fin_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (csr_wr_en) begin
         offset_in = (csr_wr_data > OFFSET_MAX) ? OFFSET_MAX : csr_wr_data;
      end

      if (fin_move) begin
         fin_valid_in = 1'b0;
      end
      if (accept) begin
         if (req_tlast) begin
            // hand the finished string on and start a fresh one
            parse_in         = '0;
            pos_in           = '0;
            fin_in.p         = parse_next;
            fin_in.too_short = too_short;
            fin_in.sec_full  = sec_full;
            fin_valid_in     = 1'b1;
         end else begin
            parse_in = parse_next;
            pos_in   = pos_next;
         end
      end

      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (fin_move) begin
         out_in       = res;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= OFFSET_RESET;
         pos_ff       <= '0;
         parse_ff     <= '0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         pos_ff       <= pos_in;
         parse_ff     <= parse_in;
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.second, out_ff.minute, out_ff.hour,
                        out_ff.day, out_ff.month, out_ff.year};
   assign rsp_tuser  = out_ff.status;

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the ASN.1 time parser: directed strings, then random ones.
module tb_top;
   import asn1tp_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int POS_CAP         = (POSITION_LIMIT_DEF > 63) ? 63 : POSITION_LIMIT_DEF;
   localparam int CHARS_PER_PHASE = 80;

   localparam logic [7:0] CHAR_ZULU = 8'h5A;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   // a '~' in a directed string stands for a zero byte
   localparam logic [7:0] ZERO_MARK = 8'h7E;

   localparam result_type MALFORMED = {STATUS_BAD, 42'd0};

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'd0;   // [7:0] char_code
   logic        req_tuser   = 1'b0;   // [0] string_kind
   logic        req_tlast   = 1'b0;   // last_char
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [47:0] rsp_tdata;            // year, month, day, hour, minute, second
   logic        rsp_tuser;            // [0] status
   logic        csr_wr_en   = 1'b0;
   logic [4:0]  csr_wr_data = 5'd0;

   // parser state as seen by the local-time predictor
   int   parse_pos     = 0;
   logic parse_kind    = KIND_UTC;
   int   acc_year      = 0;
   int   acc_month     = 0;
   int   acc_day       = 0;
   int   acc_hour      = 0;
   int   acc_minute    = 0;
   int   acc_second    = 0;
   logic sec_digits_ok = 1'b0;
   logic saw_bad_char  = 1'b0;
   int   local_offset  = OFFSET_RESET;

   result_type times_due [$];
   logic [7:0] line_buf [$];
   logic       line_kind;

   string      row_text  [$];
   logic       row_kind  [$];
   logic       row_typed [$];
   result_type row_want  [$];

   int mismatches    = 0;
   int chars_sent    = 0;
   int strings_sent  = 0;
   int results_seen  = 0;
   int results_bad   = 0;
   int stall_cycles  = 0;
   int ready_hold    = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   asn1_time_parse_to_local_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   task automatic report(input string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report($sformatf("%s got %0d, want %0d", name, got, want));
   endtask

   // Advance the parser by one character; on the last one, give the local time.
   task automatic parse_char(input logic [7:0] c, input logic k, input logic l,
                             output result_type r);
      int   need, ylen, dv, y, mo, d, h, dim;
      logic dig, bad;
      r   = '0;
      dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      dv  = dig ? int'(c - CHAR_ZERO) : 0;
      if (parse_pos == 0)
         parse_kind = k;
      need = (parse_kind == KIND_GEN) ? int'(REQ_LEN_GEN) : int'(REQ_LEN_UTC);
      ylen = (parse_kind == KIND_GEN) ? int'(YEAR_LEN_GEN) : int'(YEAR_LEN_UTC);
      if (parse_pos < POS_CAP) begin
         if (parse_pos < need) begin
            if (!dig)
               saw_bad_char = 1'b1;
            else if (parse_pos < ylen)
               acc_year = (acc_year * 10 + dv) & 'h3FFF;
            else begin
               case ((parse_pos - ylen) >> 1)
                  0:       acc_month  = (acc_month * 10 + dv) & 'h7F;
                  1:       acc_day    = (acc_day * 10 + dv) & 'h7F;
                  2:       acc_hour   = (acc_hour * 10 + dv) & 'h7F;
                  default: acc_minute = (acc_minute * 10 + dv) & 'h7F;
               endcase
            end
         end else if (parse_pos == need) begin
            sec_digits_ok = dig;
            acc_second    = dv;
         end else if (parse_pos == need + 1) begin
            sec_digits_ok = sec_digits_ok && dig;
            acc_second    = (acc_second * 10 + dv) & 'h7F;
         end
         parse_pos++;
      end
      if (l) begin
         bad = saw_bad_char || (parse_pos < need);
         y   = acc_year;
         mo  = acc_month;
         d   = acc_day;
         h   = acc_hour;
         if (parse_kind == KIND_UTC)
            y += (y < 50) ? 2000 : 1900;
         else if (y == 0)
            bad = 1'b1;
         if (mo < 1 || mo > 12 || d < 1 || d > 31 || h > 24)
            bad = 1'b1;
         if (bad) begin
            r = MALFORMED;
         end else begin
            case (mo)
               2:           dim = 28;
               4, 6, 9, 11: dim = 30;
               default:     dim = 31;
            endcase
            if (mo == 2 && ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)))
               dim = 29;
            h += local_offset;
            if (h >= 24) begin
               h -= 24;
               d++;
               if (d > dim) begin
                  d = 1;
                  mo++;
               end
               if (mo > 12) begin
                  y++;
                  mo = 1;
               end
            end
            r.year   = 14'(y);
            r.month  = 4'(mo);
            r.day    = 5'(d);
            r.hour   = 5'(h);
            r.minute = 7'(acc_minute);
            r.second = (sec_digits_ok && parse_pos >= need + 2) ? 7'(acc_second) : 7'd0;
            r.status = STATUS_OK;
         end
         // start over for the next string
         parse_pos     = 0;
         parse_kind    = KIND_UTC;
         acc_year      = 0;
         acc_month     = 0;
         acc_day       = 0;
         acc_hour      = 0;
         acc_minute    = 0;
         acc_second    = 0;
         sec_digits_ok = 1'b0;
         saw_bad_char  = 1'b0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_char(input logic [7:0] c, input logic k, input logic l,
                            input logic burst, input logic typed, input result_type want);
      int         gap, pick;
      result_type r;
      pick = $urandom_range(0, 19);
      if (burst || pick < 12)
         gap = 0;
      else if (pick < 18)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= k;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      chars_sent++;
      parse_char(c, k, l, r);
      if (l)
         times_due.push_back(typed ? want : r);
      @(negedge clock);
   endtask

   task automatic send_line(input logic typed, input result_type want);
      logic burst;
      burst = ($urandom_range(0, 4) == 0);
      strings_sent++;
      for (int i = 0; i < line_buf.size(); i++)
         send_char(line_buf[i], (i == 0) ? line_kind : 1'($urandom_range(0, 1)),
                   (i == line_buf.size() - 1), burst, typed, want);
   endtask

   task automatic add_row(input string s, input logic k, input logic typed,
                          input result_type want);
      row_text.push_back(s);
      row_kind.push_back(k);
      row_typed.push_back(typed);
      row_want.push_back(want);
   endtask

   function automatic result_type local_time(input int y, input int mo, input int d,
                                             input int h, input int mi, input int s);
      result_type r;
      r.status = STATUS_OK;
      r.year   = 14'(y);
      r.month  = 4'(mo);
      r.day    = 5'(d);
      r.hour   = 5'(h);
      r.minute = 7'(mi);
      r.second = 7'(s);
      return r;
   endfunction

   task automatic push_num(input int v, input int digits);
      int div;
      div = 1;
      for (int i = 1; i < digits; i++)
         div *= 10;
      for (; div > 0; div /= 10)
         line_buf.push_back(8'(int'(CHAR_ZERO) + (v / div) % 10));
   endtask

   // Mostly well-formed strings biased toward rollovers, with some damaged ones.
   task automatic gen_line();
      int pick, yv, mo, dy, hr, n;
      line_buf.delete();
      line_kind = 1'($urandom_range(0, 1));
      if (line_kind == KIND_GEN) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       yv = 2000;
            1:       yv = 1900;
            2:       yv = 2100;
            3:       yv = $urandom_range(0, 1) ? 9999 : 0;
            4:       yv = 4 * $urandom_range(1, 2499);
            default: yv = $urandom_range(1, 9999);
         endcase
         push_num(yv, 4);
      end else begin
         push_num($urandom_range(0, 99), 2);
      end
      mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0)
         dy = $urandom_range(0, 99);
      else
         dy = $urandom_range(0, 1) ? $urandom_range(28, 31) : $urandom_range(1, 31);
      pick = $urandom_range(0, 19);
      if (pick == 0)
         hr = $urandom_range(25, 99);
      else if (pick < 11)
         hr = $urandom_range(16, 24);
      else
         hr = $urandom_range(0, 23);
      push_num(mo, 2);
      push_num(dy, 2);
      push_num(hr, 2);
      push_num($urandom_range(0, 99), 2);
      pick = $urandom_range(0, 3);
      if (pick >= 2)
         push_num($urandom_range(0, 99), 2);
      else if (pick == 1)
         push_num($urandom_range(0, 9), 1);
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         line_buf.push_back(CHAR_ZULU);
      end else if (pick == 3) begin
         line_buf.push_back(CHAR_DOT);
         push_num($urandom_range(0, 999), 3);
      end else if (pick == 4) begin
         n = $urandom_range(33, 45);
         while (line_buf.size() < n)
            line_buf.push_back(8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick == 1) begin
         n = $urandom_range(1, line_buf.size() - 1);
         while (line_buf.size() > n)
            void'(line_buf.pop_back());
      end else if (pick == 2) begin
         line_buf.delete();
         n = $urandom_range(1, 20);
         repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Write the offset only with nothing in flight.
   task automatic set_offset(input logic [4:0] v);
      req_tvalid <= 1'b0;
      while (times_due.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en    <= 1'b0;
      local_offset = (v > OFFSET_MAX) ? int'(OFFSET_MAX) : int'(v);
   endtask

   // Receiver: ready runs and stalls of random length, mostly short stalls.
   always @(negedge clock) begin
      if (ready_hold == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(1, 30);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
         end
      end else begin
         ready_hold--;
      end
   end

   always @(posedge clock) begin
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[41:0]};
         results_seen++;
         if (rsp_tdata[47:42] != 6'd0)
            report($sformatf("padding bits set: %b", rsp_tdata[47:42]));
         if (times_due.size() == 0) begin
            report("result with nothing expected");
         end else begin
            want = times_due.pop_front();
            if (want.status == STATUS_BAD)
               results_bad++;
            check_field("status", int'(got.status), int'(want.status));
            check_field("year",   int'(got.year),   int'(want.year));
            check_field("month",  int'(got.month),  int'(want.month));
            check_field("day",    int'(got.day),    int'(want.day));
            check_field("hour",   int'(got.hour),   int'(want.hour));
            check_field("minute", int'(got.minute), int'(want.minute));
            check_field("second", int'(got.second), int'(want.second));
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, times_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [4:0] offsets [5];
      int         target;
      offsets = '{5'd0, 5'd31, 5'd23, 5'd24, 5'd0};
      offsets[4] = 5'($urandom_range(0, 31));

      // offset at its reset value of 8 for the directed rows
      add_row("4912311600",       KIND_UTC, 1'b1, local_time(2050, 1, 1, 0, 0, 0));
      add_row("5001010000",       KIND_UTC, 1'b1, local_time(1950, 1, 1, 8, 0, 0));
      add_row("99991231235959Z",  KIND_GEN, 1'b1, local_time(10000, 1, 1, 7, 59, 59));
      add_row("000001010000",     KIND_GEN, 1'b1, MALFORMED);
      add_row("20000228200000",   KIND_GEN, 1'b0, '0);
      add_row("19000228200000",   KIND_GEN, 1'b0, '0);
      add_row("9902282000",       KIND_UTC, 1'b0, '0);
      add_row("0002282000",       KIND_UTC, 1'b0, '0);
      add_row("2001012400",       KIND_UTC, 1'b0, '0);
      add_row("2001012500",       KIND_UTC, 1'b1, MALFORMED);
      add_row("2013010000",       KIND_UTC, 1'b1, MALFORMED);
      add_row("2000010000",       KIND_UTC, 1'b1, MALFORMED);
      add_row("2001320000",       KIND_UTC, 1'b1, MALFORMED);
      add_row("2001000000",       KIND_UTC, 1'b1, MALFORMED);
      add_row("200101000",        KIND_UTC, 1'b1, MALFORMED);
      add_row("20000101000",      KIND_GEN, 1'b1, MALFORMED);
      add_row("20010100a0",       KIND_UTC, 1'b1, MALFORMED);
      add_row("2001~10000",       KIND_UTC, 1'b1, MALFORMED);
      add_row("2001\3771000",     KIND_UTC, 1'b1, MALFORMED);
      add_row("200101/000",       KIND_UTC, 1'b1, MALFORMED);
      add_row("20010100:0",       KIND_UTC, 1'b1, MALFORMED);
      add_row("2004311200",       KIND_UTC, 1'b0, '0);
      add_row("2004302000",       KIND_UTC, 1'b0, '0);
      add_row("2001011299",       KIND_UTC, 1'b0, '0);
      add_row("20010112005",      KIND_UTC, 1'b0, '0);
      add_row("20010112005Z",     KIND_UTC, 1'b0, '0);
      add_row("200101120030ZZZZZZZZZZZZZZZZZZZZZZZZZZZZZZ", KIND_UTC, 1'b0, '0);
      add_row("7",                KIND_GEN, 1'b1, MALFORMED);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < row_text.size(); r++) begin
         line_buf.delete();
         for (int i = 0; i < row_text[r].len(); i++)
            line_buf.push_back((row_text[r][i] == ZERO_MARK) ? 8'h00 : row_text[r][i]);
         line_kind = row_kind[r];
         send_line(row_typed[r], row_want[r]);
      end

      foreach (offsets[p]) begin
         set_offset(offsets[p]);
         target = chars_sent + CHARS_PER_PHASE;
         while (chars_sent < target) begin
            gen_line();
            send_line(1'b0, MALFORMED);
         end
      end

      req_tvalid <= 1'b0;
      while (times_due.size() != 0)
         @(posedge clock);
      // hold a little longer to catch stray results
      repeat (10) @(posedge clock);

      $display("Sent %0d characters in %0d strings; checked %0d results, %0d malformed.",
               chars_sent, strings_sent, results_seen, results_bad);
      $display("Offsets used: reset 8, then 0, 31, 23, 24 and %0d; %0d mismatches.",
               offsets[4], mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
